/* rtl/nctb_pkg.sv */
package nctb_pkg;

   localparam int TIME_W  = 32;
   localparam int DUR_W   = 48;
   localparam int SEC_W   = 31;
   localparam int ALU_W   = DUR_W + 1;
   localparam int CMD_W   = 4;
   localparam int NAME_W  = 64;
   localparam int PLEN_W  = 4;
   localparam int REQ_W   = CMD_W + NAME_W + PLEN_W + TIME_W + TIME_W;
   localparam int RSP_W   = 40;
   localparam int RSP_USED_W = 2 + SEC_W + 1;

   localparam logic [SEC_W-1:0] SEC_MAX = {SEC_W{1'b1}};
   localparam logic [DUR_W-1:0] DUR_MAX = {1'b0, {(DUR_W-1){1'b1}}};

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE           = 4'd0,
      CMD_SET              = 4'd1,
      CMD_START            = 4'd2,
      CMD_STOP             = 4'd3,
      CMD_REMAINING        = 4'd4,
      CMD_EXPIRED          = 4'd5,
      CMD_EXPIRED_DESTROY  = 4'd6,
      CMD_DESTROY          = 4'd7,
      CMD_DESTROY_ALL      = 4'd8,
      CMD_CREATE_SET_START = 4'd9,
      CMD_PAUSE_OTHERS     = 4'd10,
      CMD_UNPAUSE_ALL      = 4'd11
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EXISTS    = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

endpackage

/* rtl/nctb_ram.sv */
module nctb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/nctb_alu.sv */
module nctb_alu
   import nctb_pkg::*;
(
   input  logic             clock,
   input  alu_req_type      req,
   output logic [ALU_W-1:0] res
);

   logic [ALU_W-1:0] res_ff;
   logic [ALU_W-1:0] res_in;

   // Subtraction is the two's complement sum with the carry in set.
   assign res_in = req.a + (req.b ^ {ALU_W{req.sub}}) + {{(ALU_W-1){1'b0}}, req.sub};

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

/* rtl/named_countdown_timer_bank.sv */
// Bank of named countdown timers.
// Commands arrive as beats on the req_ channel; each beat produces exactly one
// beat on the rsp_ channel carrying a status, the remaining whole seconds and
// an expiry flag. Timer keys, durations and time stamps live in a single RAM;
// valid, running and paused flags are flip-flops.
// Lookup commands scan the RAM one slot per cycle, then run up to two passes
// through the shared 49-bit adder. Pause walks read and check each slot in
// turn, and unpause walks also run two adder passes per paused timer.
// req_tready is high only while the block is idle, so one command is in work
// at a time.
// The result sits in an output register: the block may take the next request
// while that result is still waiting, and a stalled receiver only holds the
// block when a second result is ready to be written.
// Reset (synchronous) empties the table and drops any pending result; the RAM
// contents need no clearing since every slot is written when it is created.
module named_countdown_timer_bank
   import nctb_pkg::*;
#(
   parameter int TIMER_SLOTS    = 16,
   parameter int NAME_BYTES     = 8,
   parameter int TIME_FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // cmd[3:0], name_key[67:4], prefix_len[71:68], duration_sec[103:72], now[135:104]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status[1:0], remaining_sec[32:2], expired[33], zero padding above
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
   localparam int KEY_W = NAME_BYTES * 8;
   localparam int ENT_W = KEY_W + DUR_W + 2 * TIME_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_ELAPSED,
      S_SUBTRACT,
      S_TRUNC,
      S_UPDATE,
      S_WALK_RD,
      S_WALK_CHK,
      S_UNP_ADD,
      S_UNP_WR,
      S_RESPOND
   } state_type;

   // Request fields.
   logic [CMD_W-1:0]  req_cmd;
   logic [NAME_W-1:0] req_key;
   logic [PLEN_W-1:0] req_plen;
   logic [TIME_W-1:0] req_sec;
   logic [TIME_W-1:0] req_now;
   logic [KEY_W-1:0]  norm_key;
   logic [PLEN_W-1:0] plen_sat;

   // Control and item registers.
   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  raw_ff, raw_in;
   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic [TIME_W-1:0] dur_sec_ff, dur_sec_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  fidx_ff, fidx_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]  tgt_ff, tgt_in;
   logic [ENT_W-1:0]  ent_ff, ent_in;
   logic [SEC_W-1:0]  rem_ff, rem_in;
   logic              exp_ff, exp_in;
   status_type        status_ff, status_in;
   logic [TIMER_SLOTS-1:0] valid_ff, valid_in;
   logic [TIMER_SLOTS-1:0] run_ff, run_in;
   logic [TIMER_SLOTS-1:0] paused_ff, paused_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   // RAM and adder.
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [ENT_W-1:0]  ram_wdata;
   logic [IDX_W-1:0]  ram_raddr;
   logic [ENT_W-1:0]  ram_rdata;
   alu_req_type       alu_req;
   logic [ALU_W-1:0]  alu_res;

   // Entry fields.
   logic [KEY_W-1:0]  rd_key, ent_key;
   logic [DUR_W-1:0]  rd_dur, ent_dur;
   logic [TIME_W-1:0] rd_start, ent_start;
   logic [TIME_W-1:0] rd_pause, ent_pause;

   logic [IDX_W-1:0]  widx;
   logic              scan_hit;
   logic              differ;
   logic [DUR_W-1:0]  dur_new;
   logic              pos_new;
   logic              ent_pos;
   logic [DUR_W-1:0]  stop_dur;
   logic [ALU_W-1:0]  shifted;
   logic              too_small;
   logic [SEC_W-1:0]  trunc_sec;
   logic [DUR_W-1:0]  sat_dur;

   assign req_cmd  = req_tdata[3:0];
   assign req_key  = req_tdata[67:4];
   assign req_plen = req_tdata[71:68];
   assign req_sec  = req_tdata[103:72];
   assign req_now  = req_tdata[135:104];

   // A name ends at its first zero byte; later bytes read as zero.
   always_comb begin
      logic keep;
      keep     = 1'b1;
      norm_key = '0;
      for (int b = 0; b < NAME_BYTES; b++) begin
         if (req_key[8*b +: 8] == 8'd0) begin
            keep = 1'b0;
         end
         if (keep) begin
            norm_key[8*b +: 8] = req_key[8*b +: 8];
         end
      end
   end

   assign plen_sat = (req_plen > PLEN_W'(NAME_BYTES)) ? PLEN_W'(NAME_BYTES) : req_plen;

   assign rd_key    = ram_rdata[KEY_W-1:0];
   assign rd_dur    = ram_rdata[KEY_W +: DUR_W];
   assign rd_start  = ram_rdata[KEY_W+DUR_W +: TIME_W];
   assign rd_pause  = ram_rdata[KEY_W+DUR_W+TIME_W +: TIME_W];
   assign ent_key   = ent_ff[KEY_W-1:0];
   assign ent_dur   = ent_ff[KEY_W +: DUR_W];
   assign ent_start = ent_ff[KEY_W+DUR_W +: TIME_W];
   assign ent_pause = ent_ff[KEY_W+DUR_W+TIME_W +: TIME_W];

   assign widx     = cnt_ff[IDX_W-1:0];
   assign scan_hit = chk_vld_ff && valid_ff[chk_idx_ff] && (rd_key == key_ff);

   always_comb begin
      differ = 1'b0;
      for (int b = 0; b < NAME_BYTES; b++) begin
         if ((PLEN_W'(b) < plen_ff) && (raw_ff[8*b +: 8] != rd_key[8*b +: 8])) begin
            differ = 1'b1;
         end
      end
   end

   assign dur_new  = {{(DUR_W-TIME_W){dur_sec_ff[TIME_W-1]}}, dur_sec_ff} << TIME_FRAC_BITS;
   assign pos_new  = !dur_sec_ff[TIME_W-1] && (|dur_sec_ff);
   assign ent_pos  = !ent_dur[DUR_W-1] && (|ent_dur);
   assign stop_dur = {{(DUR_W-SEC_W){1'b0}}, rem_ff} << TIME_FRAC_BITS;

   // Remaining time below one whole second counts as expired.
   assign shifted   = alu_res >> TIME_FRAC_BITS;
   assign too_small = alu_res[ALU_W-1] || (shifted == '0);
   assign trunc_sec = too_small ? '0 :
                      (|shifted[ALU_W-1:SEC_W]) ? SEC_MAX : shifted[SEC_W-1:0];

   assign sat_dur = (!alu_res[ALU_W-1] && alu_res[DUR_W-1]) ? DUR_MAX : alu_res[DUR_W-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      raw_in       = raw_ff;
      plen_in      = plen_ff;
      dur_sec_in   = dur_sec_ff;
      now_in       = now_ff;
      cnt_in       = cnt_ff;
      chk_vld_in   = chk_vld_ff;
      chk_idx_in   = chk_idx_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      tgt_in       = tgt_ff;
      ent_in       = ent_ff;
      rem_in       = rem_ff;
      exp_in       = exp_ff;
      status_in    = status_ff;
      valid_in     = valid_ff;
      run_in       = run_ff;
      paused_in    = paused_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = tgt_ff;
      ram_wdata    = ent_ff;
      ram_raddr    = widx;
      alu_req      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in      = cmd_type'(req_cmd);
               key_in      = norm_key;
               raw_in      = req_key[KEY_W-1:0];
               plen_in     = plen_sat;
               dur_sec_in  = req_sec;
               now_in      = req_now;
               cnt_in      = '0;
               chk_vld_in  = 1'b0;
               found_in    = 1'b0;
               free_in     = 1'b0;
               rem_in      = '0;
               exp_in      = 1'b0;
               status_in   = ST_OK;
               case (req_cmd)
                  CMD_CREATE, CMD_SET, CMD_START, CMD_STOP, CMD_REMAINING, CMD_EXPIRED,
                  CMD_EXPIRED_DESTROY, CMD_DESTROY, CMD_CREATE_SET_START: begin
                     state_in = S_SCAN;
                  end
                  CMD_PAUSE_OTHERS, CMD_UNPAUSE_ALL: begin
                     state_in = S_WALK_RD;
                  end
                  CMD_DESTROY_ALL: begin
                     valid_in  = '0;
                     run_in    = '0;
                     paused_in = '0;
                     state_in  = S_RESPOND;
                  end
                  default: begin
                     state_in = S_RESPOND;
                  end
               endcase
            end
         end

         // Reads are issued one slot per cycle and each is checked in the following cycle.
         S_SCAN: begin
            chk_vld_in = 1'b0;
            if (cnt_ff < CNT_W'(TIMER_SLOTS)) begin
               cnt_in     = cnt_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = widx;
            end
            if (scan_hit && !found_ff) begin
               found_in = 1'b1;
               fidx_in  = chk_idx_ff;
               ent_in   = ram_rdata;
            end
            if (chk_vld_ff && !valid_ff[chk_idx_ff] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = chk_idx_ff;
            end
            if (chk_vld_ff && (chk_idx_ff == LAST_IDX)) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            state_in = S_RESPOND;
            case (cmd_ff)
               CMD_CREATE: begin
                  if (found_ff) begin
                     status_in = ST_EXISTS;
                  end else if (free_ff) begin
                     tgt_in   = free_idx_ff;
                     state_in = S_UPDATE;
                  end else begin
                     status_in = ST_FULL;
                  end
               end
               CMD_CREATE_SET_START: begin
                  if (found_ff) begin
                     status_in = ST_EXISTS;
                     tgt_in    = fidx_ff;
                     state_in  = S_UPDATE;
                  end else if (free_ff) begin
                     tgt_in   = free_idx_ff;
                     state_in = S_UPDATE;
                  end else begin
                     status_in = ST_FULL;
                  end
               end
               CMD_SET, CMD_START, CMD_DESTROY: begin
                  if (!found_ff) begin
                     status_in = ST_NOT_FOUND;
                  end else begin
                     tgt_in   = fidx_ff;
                     state_in = S_UPDATE;
                  end
               end
               CMD_STOP, CMD_REMAINING, CMD_EXPIRED, CMD_EXPIRED_DESTROY: begin
                  if (!found_ff) begin
                     status_in = ST_NOT_FOUND;
                  end else begin
                     tgt_in = fidx_ff;
                     if (paused_ff[fidx_ff]) begin
                        rem_in   = SEC_MAX;
                        state_in = S_UPDATE;
                     end else if (!run_ff[fidx_ff]) begin
                        rem_in   = '0;
                        state_in = S_UPDATE;
                     end else begin
                        state_in = S_ELAPSED;
                     end
                  end
               end
               default: begin
                  state_in = S_RESPOND;
               end
            endcase
         end

         S_ELAPSED: begin
            alu_req.a   = {{(ALU_W-TIME_W){1'b0}}, now_ff};
            alu_req.b   = {{(ALU_W-TIME_W){1'b0}}, ent_start};
            alu_req.sub = 1'b1;
            state_in    = S_SUBTRACT;
         end

         // The elapsed time wraps modulo 2^32, so only its low word is used.
         S_SUBTRACT: begin
            alu_req.a   = {ent_dur[DUR_W-1], ent_dur};
            alu_req.b   = {{(ALU_W-TIME_W){1'b0}}, alu_res[TIME_W-1:0]};
            alu_req.sub = 1'b1;
            state_in    = S_TRUNC;
         end

         S_TRUNC: begin
            rem_in = trunc_sec;
            if (too_small) begin
               run_in[tgt_ff] = 1'b0;
            end
            state_in = S_UPDATE;
         end

         S_UPDATE: begin
            state_in = S_RESPOND;
            case (cmd_ff)
               CMD_CREATE: begin
                  ram_we            = 1'b1;
                  ram_wdata         = {{(ENT_W-KEY_W){1'b0}}, key_ff};
                  valid_in[tgt_ff]  = 1'b1;
                  run_in[tgt_ff]    = 1'b0;
                  paused_in[tgt_ff] = 1'b0;
               end
               CMD_CREATE_SET_START: begin
                  ram_we    = 1'b1;
                  ram_wdata = {found_ff ? ent_pause : {TIME_W{1'b0}},
                               pos_new ? now_ff : (found_ff ? ent_start : {TIME_W{1'b0}}),
                               dur_new, key_ff};
                  valid_in[tgt_ff] = 1'b1;
                  run_in[tgt_ff]   = pos_new;
                  if (pos_new || !found_ff) begin
                     paused_in[tgt_ff] = 1'b0;
                  end
               end
               CMD_SET: begin
                  ram_we    = 1'b1;
                  ram_wdata = {ent_pause, ent_start, dur_new, ent_key};
               end
               CMD_START: begin
                  if (ent_pos) begin
                     ram_we            = 1'b1;
                     ram_wdata         = {ent_pause, now_ff, ent_dur, ent_key};
                     run_in[tgt_ff]    = 1'b1;
                     paused_in[tgt_ff] = 1'b0;
                  end else begin
                     run_in[tgt_ff] = 1'b0;
                  end
               end
               CMD_STOP: begin
                  ram_we         = 1'b1;
                  ram_wdata      = {ent_pause, ent_start, stop_dur, ent_key};
                  run_in[tgt_ff] = 1'b0;
               end
               CMD_EXPIRED: begin
                  exp_in = (rem_ff == '0);
               end
               CMD_EXPIRED_DESTROY: begin
                  exp_in = (rem_ff == '0);
                  if (rem_ff == '0) begin
                     valid_in[tgt_ff] = 1'b0;
                  end
               end
               CMD_DESTROY: begin
                  valid_in[tgt_ff] = 1'b0;
                  exp_in           = 1'b1;
               end
               default: begin
                  exp_in = 1'b0;
               end
            endcase
         end

         S_WALK_RD: begin
            state_in = S_WALK_CHK;
         end

         S_WALK_CHK: begin
            ent_in    = ram_rdata;
            ram_waddr = widx;
            if ((cmd_ff == CMD_UNPAUSE_ALL) && valid_ff[widx] && paused_ff[widx]) begin
               alu_req.a   = {{(ALU_W-TIME_W){1'b0}}, now_ff};
               alu_req.b   = {{(ALU_W-TIME_W){1'b0}}, rd_pause};
               alu_req.sub = 1'b1;
               state_in    = S_UNP_ADD;
            end else begin
               if ((cmd_ff == CMD_PAUSE_OTHERS) && valid_ff[widx] && differ) begin
                  ram_we          = 1'b1;
                  ram_wdata       = {now_ff, rd_start, rd_dur, rd_key};
                  paused_in[widx] = 1'b1;
               end
               if (widx == LAST_IDX) begin
                  state_in = S_RESPOND;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_WALK_RD;
               end
            end
         end

         S_UNP_ADD: begin
            alu_req.a   = {ent_dur[DUR_W-1], ent_dur};
            alu_req.b   = {{(ALU_W-TIME_W){1'b0}}, alu_res[TIME_W-1:0]};
            alu_req.sub = 1'b0;
            state_in    = S_UNP_WR;
         end

         S_UNP_WR: begin
            ram_we          = 1'b1;
            ram_waddr       = widx;
            ram_wdata       = {ent_pause, ent_start, sat_dur, ent_key};
            paused_in[widx] = 1'b0;
            if (widx == LAST_IDX) begin
               state_in = S_RESPOND;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_WALK_RD;
            end
         end

         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_W-RSP_USED_W){1'b0}}, exp_ff, rem_ff, status_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      raw_ff      <= raw_in;
      plen_ff     <= plen_in;
      dur_sec_ff  <= dur_sec_in;
      now_ff      <= now_in;
      chk_idx_ff  <= chk_idx_in;
      fidx_ff     <= fidx_in;
      free_idx_ff <= free_idx_in;
      tgt_ff      <= tgt_in;
      ent_ff      <= ent_in;
      rem_ff      <= rem_in;
      exp_ff      <= exp_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         valid_ff     <= '0;
         run_ff       <= '0;
         paused_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_vld_ff   <= chk_vld_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         valid_ff     <= valid_in;
         run_ff       <= run_in;
         paused_ff    <= paused_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   nctb_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TIMER_SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   nctb_alu u_alu (
      .clock (clock),
      .req   (alu_req),
      .res   (alu_res)
   );

endmodule

/* rtl/nctb_checker.sv */
module nctb_checker
   import nctb_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] pend_ff, pend_in;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // Requests taken but not yet answered.
   assign pend_in = pend_ff + {1'b0, req_beat} - {1'b0, rsp_beat};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // The block works on one command at a time.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_tready)
      else $error("request taken while a command was still in work");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pend_ff != 2'd0))
      else $error("result offered with no request outstanding");

   // At most one result waiting plus one command in work.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two requests outstanding");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   a_rsp_padding: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_W-1:RSP_USED_W] == '0))
      else $error("padding bits of the result beat are not zero");

endmodule

bind named_countdown_timer_bank nctb_checker u_nctb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
